// ----- design/wavhdr_pkg.sv -----
// Shared types, constants and tag tables for the WAVE header parser.
// Depends on nothing; used by wavhdr_result and wav_header_chunk_parser.
`default_nettype none

package wavhdr_pkg;

	// Width of the byte position counter; offsets saturate at all ones
	localparam int OFFSET_BITS = 32;
	// Width of the clamp arithmetic: wide enough for offset plus a 32-bit size
	localparam int SUM_W = ((OFFSET_BITS > 32) ? OFFSET_BITS : 32) + 1;
	// Chunk byte countdown: a 32-bit size plus its pad byte
	localparam int LEFT_W = 33;

	typedef logic [OFFSET_BITS-1:0] wavhdr_pos_t;
	typedef logic [SUM_W-1:0]       wavhdr_sum_t;
	typedef logic [LEFT_W-1:0]      wavhdr_left_t;

	localparam wavhdr_pos_t POS_MAX  = '1;
	localparam int          MIN_FILE = 44;
	localparam int          FMT_MIN  = 16;
	localparam int          HDR_LEN  = 8;
	localparam logic [31:0] ID_FMT   = 32'h2074_6D66;
	localparam logic [31:0] ID_DATA  = 32'h6174_6164;

	// Result status codes
	localparam logic [2:0] ST_OK      = 3'd0;
	localparam logic [2:0] ST_SHORT   = 3'd1;
	localparam logic [2:0] ST_BAD_TAG = 3'd2;
	localparam logic [2:0] ST_MISSING = 3'd3;
	localparam logic [2:0] ST_DEPTH   = 3'd4;

	// Format code: more than one channel in the upper bit, 16-bit depth in the lower
	localparam logic [1:0] FMT_MONO8 = 2'd0;

	typedef enum logic [1:0] {
		PH_PRE  = 2'd0,
		PH_HDR  = 2'd1,
		PH_BODY = 2'd2
	} wavhdr_phase_t;

	typedef struct packed {
		logic [7:0] byte_value;
		logic       last_byte;
	} wavhdr_in_t;

	typedef struct packed {
		logic [2:0]  status;
		logic [15:0] channel_count;
		logic [31:0] sample_rate_hz;
		logic [15:0] bits_per_sample;
		logic [1:0]  pcm_format;
		logic [31:0] pcm_offset;
		logic [31:0] pcm_length;
	} wavhdr_out_t;

	// Parser state at the end of a file, handed to the result logic
	typedef struct packed {
		wavhdr_pos_t fsize;
		logic        tag_ok;
		logic        data_seen;
		wavhdr_pos_t data_start;
		logic [31:0] data_size;
		logic [15:0] channels;
		logic [31:0] rate;
		logic [15:0] bits;
	} wavhdr_snap_t;

	// "RIFF" at offsets 0..3
	function automatic logic [7:0] riff_byte(input logic [1:0] idx);
		logic [7:0] v;
		unique case (idx)
			2'd0: v = 8'h52;
			2'd1: v = 8'h49;
			2'd2: v = 8'h46;
			2'd3: v = 8'h46;
			default: v = 8'h00;
		endcase
		return v;
	endfunction

	// "WAVE" at offsets 8..11
	function automatic logic [7:0] wave_byte(input logic [1:0] idx);
		logic [7:0] v;
		unique case (idx)
			2'd0: v = 8'h57;
			2'd1: v = 8'h41;
			2'd2: v = 8'h56;
			2'd3: v = 8'h45;
			default: v = 8'h00;
		endcase
		return v;
	endfunction

endpackage

`default_nettype wire

// ----- design/wavhdr_result.sv -----
// End-of-file result logic: clamps the data length and ranks the status.
// Depends on wavhdr_pkg.
`default_nettype none

module wavhdr_result (
	input  wire wavhdr_pkg::wavhdr_snap_t snap,
	output wavhdr_pkg::wavhdr_out_t       res
);

	wavhdr_pkg::wavhdr_sum_t fsize_w;
	wavhdr_pkg::wavhdr_sum_t start_w;
	wavhdr_pkg::wavhdr_sum_t size_w;
	wavhdr_pkg::wavhdr_sum_t end_w;
	wavhdr_pkg::wavhdr_sum_t offs;
	wavhdr_pkg::wavhdr_sum_t len;
	logic                    depth_ok;

	// Data span, clamped to the end of the file
	always_comb begin
		fsize_w = wavhdr_pkg::wavhdr_sum_t'(snap.fsize);
		start_w = wavhdr_pkg::wavhdr_sum_t'(snap.data_start);
		size_w  = wavhdr_pkg::wavhdr_sum_t'(snap.data_size);
		end_w   = start_w + size_w;
		offs    = '0;
		len     = '0;
		if (snap.data_seen) begin
			offs = start_w;
			len  = (end_w > fsize_w) ? (fsize_w - start_w) : size_w;
		end
	end

	assign depth_ok = (snap.bits == 16'd8) || (snap.bits == 16'd16);

	// Status: first failing check wins
	always_comb begin
		res.channel_count   = snap.channels;
		res.sample_rate_hz  = snap.rate;
		res.bits_per_sample = snap.bits;
		res.pcm_offset      = offs[31:0];
		res.pcm_length      = len[31:0];
		res.pcm_format      = wavhdr_pkg::FMT_MONO8;
		priority if (snap.fsize < wavhdr_pkg::wavhdr_pos_t'(wavhdr_pkg::MIN_FILE)) begin
			res.status = wavhdr_pkg::ST_SHORT;
		end else if (!snap.tag_ok) begin
			res.status = wavhdr_pkg::ST_BAD_TAG;
		end else if (!snap.data_seen || (len == '0) || (snap.channels == '0)
				|| (snap.rate == '0)) begin
			res.status = wavhdr_pkg::ST_MISSING;
		end else if (!depth_ok) begin
			res.status = wavhdr_pkg::ST_DEPTH;
		end else begin
			res.status     = wavhdr_pkg::ST_OK;
			res.pcm_format = {snap.channels != 16'd1, snap.bits == 16'd16};
		end
	end

endmodule

`default_nettype wire

// ----- design/wav_header_chunk_parser.sv -----
// Top level of the WAVE header parser: input register, chunk walker state
// and result register. Depends on wavhdr_pkg and wavhdr_result.
//
// Usage:
//  feed carries one file byte per request with a last-byte mark; a request
//  is taken when feed_valid is high and feed_stall is low.
//  result carries one item per file, raised after the byte marked last; it
//  is taken when result_valid is high and result_stall is low.
//  Throughput: one byte per cycle unless a last byte is held back. Each byte
//  is registered in the input register, where the chunk walker updates its
//  state in a single step. The last byte loads the result register.
//  Stalling: a held result blocks only a following last byte, which waits
//  in the input register; ordinary bytes keep flowing meanwhile.
//  Reset clears the walker and both valid flags; after each result the
//  walker returns to its reset state for the next file. The byte position
//  saturates at all ones, later bytes are counted as cut off.
`default_nettype none

module wav_header_chunk_parser (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire                          feed_valid,
	output logic                         feed_stall,
	input  wire wavhdr_pkg::wavhdr_in_t  feed,
	output logic                         result_valid,
	input  wire                          result_stall,
	output wavhdr_pkg::wavhdr_out_t      result
);

	// Input stage
	logic                   valid_s1;
	wavhdr_pkg::wavhdr_in_t feed_s1;
	logic                   adv_s1;
	logic                   step;
	logic                   finish;
	logic [7:0]             b;

	// Walker state
	wavhdr_pkg::wavhdr_pos_t   pos_q,   nx_pos;
	wavhdr_pkg::wavhdr_phase_t phase_q, nx_phase;
	wavhdr_pkg::wavhdr_left_t  left_q,  nx_left;
	logic [63:0]               shift_q, nx_shift;
	logic [4:0]                off_q,   nx_off;
	logic                      tag_ok_q, nx_tag_ok;
	logic                      in_fmt_q, nx_in_fmt;
	logic [15:0]               pch_q,   nx_pch;
	logic [31:0]               prate_q, nx_prate;
	logic [15:0]               pbits_q, nx_pbits;
	logic [15:0]               kch_q,   nx_kch;
	logic [31:0]               krate_q, nx_krate;
	logic [15:0]               kbits_q, nx_kbits;
	logic                      dseen_q, nx_dseen;
	wavhdr_pkg::wavhdr_pos_t   dstart_q, nx_dstart;
	logic [31:0]               dsize_q, nx_dsize;

	// Chunk header decode, valid on the eighth header byte
	logic [31:0]              hdr_id;
	logic [31:0]              hdr_size;
	wavhdr_pkg::wavhdr_left_t chunk_len;
	logic                     hdr_done;
	logic                     body_done;

	wavhdr_pkg::wavhdr_snap_t snap;
	wavhdr_pkg::wavhdr_out_t  res;
	logic                     result_valid_q;
	wavhdr_pkg::wavhdr_out_t  result_q;

	// Handshake: only a last byte can be held back by a full result register
	assign adv_s1     = valid_s1 && (!feed_s1.last_byte || !result_valid_q || !result_stall);
	assign feed_stall = valid_s1 && !adv_s1;
	assign step       = adv_s1 && (pos_q != wavhdr_pkg::POS_MAX);
	assign finish     = adv_s1 && feed_s1.last_byte;
	assign b          = feed_s1.byte_value;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (feed_valid && !feed_stall) begin
			valid_s1 <= 1'b1;
		end else if (adv_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (feed_valid && !feed_stall) begin
			feed_s1 <= feed;
		end
	end

	assign hdr_id    = shift_q[39:8];
	assign hdr_size  = {b, shift_q[63:40]};
	assign chunk_len = wavhdr_pkg::wavhdr_left_t'(hdr_size)
		+ wavhdr_pkg::wavhdr_left_t'(hdr_size[0]);
	assign hdr_done  = (left_q == wavhdr_pkg::wavhdr_left_t'(1));
	assign body_done = (left_q == wavhdr_pkg::wavhdr_left_t'(1));

	// Next phase
	always_comb begin
		nx_phase = phase_q;
		if (step) begin
			unique case (phase_q)
				wavhdr_pkg::PH_PRE: begin
					if (pos_q >= wavhdr_pkg::wavhdr_pos_t'(11)) begin
						nx_phase = wavhdr_pkg::PH_HDR;
					end
				end
				wavhdr_pkg::PH_HDR: begin
					if (hdr_done && (chunk_len != '0)) begin
						nx_phase = wavhdr_pkg::PH_BODY;
					end
				end
				wavhdr_pkg::PH_BODY: begin
					if (body_done) begin
						nx_phase = wavhdr_pkg::PH_HDR;
					end
				end
				default: nx_phase = wavhdr_pkg::PH_PRE;
			endcase
		end
	end

	// Per-byte datapath update
	always_comb begin
		nx_pos    = pos_q;
		nx_left   = left_q;
		nx_shift  = shift_q;
		nx_off    = off_q;
		nx_tag_ok = tag_ok_q;
		nx_in_fmt = in_fmt_q;
		nx_pch    = pch_q;
		nx_prate  = prate_q;
		nx_pbits  = pbits_q;
		nx_kch    = kch_q;
		nx_krate  = krate_q;
		nx_kbits  = kbits_q;
		nx_dseen  = dseen_q;
		nx_dstart = dstart_q;
		nx_dsize  = dsize_q;
		if (step) begin
			nx_pos = pos_q + wavhdr_pkg::wavhdr_pos_t'(1);
			unique case (phase_q)
				wavhdr_pkg::PH_PRE: begin
					if ((pos_q < wavhdr_pkg::wavhdr_pos_t'(4))
							&& (b != wavhdr_pkg::riff_byte(pos_q[1:0]))) begin
						nx_tag_ok = 1'b0;
					end
					if ((pos_q >= wavhdr_pkg::wavhdr_pos_t'(8))
							&& (pos_q < wavhdr_pkg::wavhdr_pos_t'(12))
							&& (b != wavhdr_pkg::wave_byte(pos_q[1:0]))) begin
						nx_tag_ok = 1'b0;
					end
					if (pos_q >= wavhdr_pkg::wavhdr_pos_t'(11)) begin
						nx_left = wavhdr_pkg::wavhdr_left_t'(wavhdr_pkg::HDR_LEN);
					end
				end
				wavhdr_pkg::PH_HDR: begin
					nx_shift = {b, shift_q[63:8]};
					nx_left  = left_q - wavhdr_pkg::wavhdr_left_t'(1);
					if (hdr_done) begin
						nx_in_fmt = (hdr_id == wavhdr_pkg::ID_FMT)
							&& (hdr_size >= 32'(wavhdr_pkg::FMT_MIN));
						if (hdr_id == wavhdr_pkg::ID_DATA) begin
							nx_dseen  = 1'b1;
							nx_dstart = pos_q + wavhdr_pkg::wavhdr_pos_t'(1);
							nx_dsize  = hdr_size;
						end
						nx_pch   = '0;
						nx_prate = '0;
						nx_pbits = '0;
						nx_off   = '0;
						nx_left  = (chunk_len == '0)
							? wavhdr_pkg::wavhdr_left_t'(wavhdr_pkg::HDR_LEN) : chunk_len;
					end
				end
				wavhdr_pkg::PH_BODY: begin
					// fmt fields live in the first sixteen body bytes
					if (in_fmt_q && !off_q[4]) begin
						unique case (off_q[3:0])
							4'd2:  nx_pch[7:0]     = b;
							4'd3:  nx_pch[15:8]    = b;
							4'd4:  nx_prate[7:0]   = b;
							4'd5:  nx_prate[15:8]  = b;
							4'd6:  nx_prate[23:16] = b;
							4'd7:  nx_prate[31:24] = b;
							4'd14: nx_pbits[7:0]   = b;
							4'd15: begin
								nx_pbits[15:8] = b;
								nx_kch         = pch_q;
								nx_krate       = prate_q;
								nx_kbits       = {b, pbits_q[7:0]};
							end
							default: ;
						endcase
					end
					if (!off_q[4]) begin
						nx_off = off_q + 5'd1;
					end
					nx_left = left_q - wavhdr_pkg::wavhdr_left_t'(1);
					if (body_done) begin
						nx_left = wavhdr_pkg::wavhdr_left_t'(wavhdr_pkg::HDR_LEN);
					end
				end
				default: ;
			endcase
		end
	end

	// Walker control state; a finished file returns it to reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q    <= '0;
			phase_q  <= wavhdr_pkg::PH_PRE;
			left_q   <= '0;
			off_q    <= '0;
			tag_ok_q <= 1'b1;
			in_fmt_q <= 1'b0;
			kch_q    <= '0;
			krate_q  <= '0;
			kbits_q  <= '0;
			dseen_q  <= 1'b0;
		end else if (finish) begin
			pos_q    <= '0;
			phase_q  <= wavhdr_pkg::PH_PRE;
			left_q   <= '0;
			off_q    <= '0;
			tag_ok_q <= 1'b1;
			in_fmt_q <= 1'b0;
			kch_q    <= '0;
			krate_q  <= '0;
			kbits_q  <= '0;
			dseen_q  <= 1'b0;
		end else begin
			pos_q    <= nx_pos;
			phase_q  <= nx_phase;
			left_q   <= nx_left;
			off_q    <= nx_off;
			tag_ok_q <= nx_tag_ok;
			in_fmt_q <= nx_in_fmt;
			kch_q    <= nx_kch;
			krate_q  <= nx_krate;
			kbits_q  <= nx_kbits;
			dseen_q  <= nx_dseen;
		end
	end

	// Payload state: only read once the matching flag or header says so
	always_ff @(posedge clk) begin
		shift_q  <= nx_shift;
		pch_q    <= nx_pch;
		prate_q  <= nx_prate;
		pbits_q  <= nx_pbits;
		dstart_q <= nx_dstart;
		dsize_q  <= nx_dsize;
	end

	// Snapshot including the last byte's own update
	always_comb begin
		snap.fsize      = nx_pos;
		snap.tag_ok     = nx_tag_ok;
		snap.data_seen  = nx_dseen;
		snap.data_start = nx_dstart;
		snap.data_size  = nx_dsize;
		snap.channels   = nx_kch;
		snap.rate       = nx_krate;
		snap.bits       = nx_kbits;
	end

	wavhdr_result u_result (
		.snap (snap),
		.res  (res)
	);

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (finish) begin
			result_valid_q <= 1'b1;
		end else if (!result_stall) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (finish) begin
			result_q <= res;
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

	// Checks
	a_last_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		finish |=> result_valid_q)
		else $error("last byte did not raise a result");

	a_restart_after_file: assert property (@(posedge clk) disable iff (!arst_n)
		finish |=> (pos_q == '0) && (phase_q == wavhdr_pkg::PH_PRE) && !dseen_q)
		else $error("walker not cleared after a file");

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		feed_stall |-> valid_s1 && feed_s1.last_byte && result_valid_q && result_stall)
		else $error("input held without a blocked result");

	a_body_count: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == wavhdr_pkg::PH_BODY) |-> (left_q != '0))
		else $error("chunk body with no bytes left");

endmodule

`default_nettype wire

// ----- tb/sv/wav_header_chunk_parser_test.sv -----
// Self-checking testbench for wav_header_chunk_parser: builds WAVE files byte by byte,
// predicts each header result and compares it field by field with the block's output.
// Depends on wavhdr_pkg and the parser RTL.
module wav_header_chunk_parser_test;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CLK_PERIOD      = 10;
	localparam int CYCLE_LIMIT     = 600000;
	localparam int DRAIN_CYCLES    = 8;
	localparam int HOLD_OFF_CYCLES = 300;
	// Random files top the run up to this many bytes in all
	localparam int ITEMS_TOTAL     = 750;
	localparam int RANDOM_FILES    = 3;
	// Tags as little-endian words, byte 0 in the low bits
	localparam logic [31:0] RIFF_TAG = 32'h4646_4952;
	localparam logic [31:0] WAVE_TAG = 32'h4556_4157;

	logic                    clk          = 1'b0;
	logic                    arst_n       = 1'b0;
	logic                    feed_valid   = 1'b0;
	logic                    feed_stall;
	wavhdr_pkg::wavhdr_in_t  feed         = '0;
	logic                    result_valid;
	logic                    result_stall = 1'b0;
	wavhdr_pkg::wavhdr_out_t result;

	// Expected header results, oldest first
	wavhdr_pkg::wavhdr_out_t expected_headers[$];
	// File under construction
	logic [7:0]  file_q[$];

	int unsigned cycle_count    = 0;
	int          mismatch_count = 0;
	int          bytes_sent     = 0;
	bit          feed_gaps_on   = 1'b1;
	bit          stall_on       = 1'b1;
	bit          hold_off_req   = 1'b0;

	// Chunk walker state of the predictor
	logic [31:0]               wav_pos;
	bit                        tags_good;
	logic [63:0]               chunk_hdr;
	wavhdr_pkg::wavhdr_phase_t wav_phase;
	logic [32:0]               chunk_left;
	bit                        in_fmt;
	logic [15:0]               pend_ch, kept_ch;
	logic [31:0]               pend_rate, kept_rate;
	logic [15:0]               pend_bits, kept_bits;
	bit                        data_found;
	logic [31:0]               data_off, data_size;

	wav_header_chunk_parser u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.feed_valid   (feed_valid),
		.feed_stall   (feed_stall),
		.feed         (feed),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	// Watchdog
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	// ---------------------------------------------------------------- predictor

	function automatic void clear_walker();
		wav_pos    = '0;
		tags_good  = 1'b1;
		chunk_hdr  = '0;
		wav_phase  = wavhdr_pkg::PH_PRE;
		chunk_left = '0;
		in_fmt     = 1'b0;
		pend_ch    = '0;
		pend_rate  = '0;
		pend_bits  = '0;
		kept_ch    = '0;
		kept_rate  = '0;
		kept_bits  = '0;
		data_found = 1'b0;
		data_off   = '0;
		data_size  = '0;
	endfunction

	// Advance the walker by one accepted byte; on the last byte queue the header result
	function automatic void walk_byte(input logic [7:0] b, input logic last);
		logic [31:0]             csize;
		logic [32:0]             body_off;
		logic [31:0]             offs, len;
		int                      o;
		wavhdr_pkg::wavhdr_out_t hdr;
		// bytes past the saturated position are dropped
		if (wav_pos != wavhdr_pkg::POS_MAX) begin
			case (wav_phase)
				wavhdr_pkg::PH_PRE: begin
					if (wav_pos < 4 && b != RIFF_TAG[8*wav_pos[1:0] +: 8])
						tags_good = 1'b0;
					if (wav_pos >= 8 && wav_pos < 12 && b != WAVE_TAG[8*wav_pos[1:0] +: 8])
						tags_good = 1'b0;
					if (wav_pos >= 11) begin
						wav_phase  = wavhdr_pkg::PH_HDR;
						chunk_left = 33'(wavhdr_pkg::HDR_LEN);
					end
				end
				wavhdr_pkg::PH_HDR: begin
					chunk_hdr = {b, chunk_hdr[63:8]};
					chunk_left--;
					if (chunk_left == 0) begin
						csize  = chunk_hdr[63:32];
						in_fmt = (chunk_hdr[31:0] == wavhdr_pkg::ID_FMT)
							&& (csize >= wavhdr_pkg::FMT_MIN);
						if (chunk_hdr[31:0] == wavhdr_pkg::ID_DATA) begin
							data_found = 1'b1;
							data_off   = wav_pos + 1;
							data_size  = csize;
						end
						pend_ch    = '0;
						pend_rate  = '0;
						pend_bits  = '0;
						chunk_left = {1'b0, csize} + csize[0];
						// empty chunk: straight on to the next header
						if (chunk_left == 0)
							chunk_left = 33'(wavhdr_pkg::HDR_LEN);
						else
							wav_phase = wavhdr_pkg::PH_BODY;
					end
				end
				default: begin
					csize    = chunk_hdr[63:32];
					body_off = {1'b0, csize} + csize[0] - chunk_left;
					if (in_fmt && body_off < wavhdr_pkg::FMT_MIN) begin
						o = int'(body_off[3:0]);
						if (o == 2 || o == 3)
							pend_ch[8*(o-2) +: 8] = b;
						else if (o >= 4 && o <= 7)
							pend_rate[8*(o-4) +: 8] = b;
						else if (o == 14 || o == 15)
							pend_bits[8*(o-14) +: 8] = b;
						// fmt fields only take effect once the 16th body byte is in
						if (o == 15) begin
							kept_ch   = pend_ch;
							kept_rate = pend_rate;
							kept_bits = pend_bits;
						end
					end
					chunk_left--;
					if (chunk_left == 0) begin
						wav_phase  = wavhdr_pkg::PH_HDR;
						chunk_left = 33'(wavhdr_pkg::HDR_LEN);
					end
				end
			endcase
			wav_pos++;
		end
		if (!last)
			return;

		offs = '0;
		len  = '0;
		if (data_found) begin
			offs = data_off;
			len  = data_size;
			// clamp the declared length to the end of the file
			if (33'(offs) + 33'(len) > 33'(wav_pos))
				len = wav_pos - offs;
		end
		if (wav_pos < wavhdr_pkg::MIN_FILE)
			hdr.status = wavhdr_pkg::ST_SHORT;
		else if (!tags_good)
			hdr.status = wavhdr_pkg::ST_BAD_TAG;
		else if (!data_found || len == 0 || kept_ch == 0 || kept_rate == 0)
			hdr.status = wavhdr_pkg::ST_MISSING;
		else if (kept_bits != 16'd8 && kept_bits != 16'd16)
			hdr.status = wavhdr_pkg::ST_DEPTH;
		else
			hdr.status = wavhdr_pkg::ST_OK;
		hdr.pcm_format = (hdr.status == wavhdr_pkg::ST_OK) ?
			{kept_ch != 16'd1, kept_bits == 16'd16} : wavhdr_pkg::FMT_MONO8;
		hdr.channel_count   = kept_ch;
		hdr.sample_rate_hz  = kept_rate;
		hdr.bits_per_sample = kept_bits;
		hdr.pcm_offset      = offs;
		hdr.pcm_length      = len;
		expected_headers.push_back(hdr);
		clear_walker();
	endfunction

	// ---------------------------------------------------------------- checking

	task automatic check_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (got !== want) begin
			$error("%s: expected %0h, got %0h", name, want, got);
			mismatch_count++;
		end
	endtask

	always @(posedge clk) begin
		wavhdr_pkg::wavhdr_out_t want;
		if (arst_n && result_valid && !result_stall) begin
			if (expected_headers.size() == 0) begin
				$error("result with none expected: status %0d", result.status);
				mismatch_count++;
			end else begin
				want = expected_headers.pop_front();
				check_field("status", want.status, result.status);
				check_field("channel_count", want.channel_count, result.channel_count);
				check_field("sample_rate_hz", want.sample_rate_hz, result.sample_rate_hz);
				check_field("bits_per_sample", want.bits_per_sample, result.bits_per_sample);
				check_field("pcm_format", want.pcm_format, result.pcm_format);
				check_field("pcm_offset", want.pcm_offset, result.pcm_offset);
				check_field("pcm_length", want.pcm_length, result.pcm_length);
			end
		end
	end

	// ---------------------------------------------------------------- traffic

	function automatic int idle_len();
		int r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	// Result side: random stalls, plus a long hold-off on request
	initial begin
		forever begin
			@(negedge clk);
			if (hold_off_req) begin
				hold_off_req = 1'b0;
				result_stall <= 1'b1;
				repeat (HOLD_OFF_CYCLES - 1) @(negedge clk);
			end else if (stall_on && $urandom_range(0, 3) == 0) begin
				result_stall <= 1'b1;
				repeat (idle_len()) @(negedge clk);
			end else begin
				result_stall <= 1'b0;
			end
		end
	end

	// One request on the feed channel, then an optional gap
	task automatic send_byte(input logic [7:0] b, input logic last);
		int                     gap;
		wavhdr_pkg::wavhdr_in_t req;
		req.byte_value = b;
		req.last_byte  = last;
		@(negedge clk);
		feed_valid <= 1'b1;
		feed       <= req;
		do @(posedge clk); while (feed_stall);
		walk_byte(b, last);
		bytes_sent++;
		gap = feed_gaps_on ? idle_len() : 0;
		if (gap > 0) begin
			@(negedge clk);
			feed_valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
	endtask

	task automatic send_file();
		logic [7:0] b;
		while (file_q.size() > 0) begin
			b = file_q.pop_front();
			send_byte(b, file_q.size() == 0);
		end
	endtask

	// ---------------------------------------------------------------- file builders

	task automatic put_le(input logic [31:0] v, input int n);
		for (int i = 0; i < n; i++)
			file_q.push_back(v[8*i +: 8]);
	endtask

	task automatic put_rand(input int n);
		for (int i = 0; i < n; i++)
			file_q.push_back(8'($urandom));
	endtask

	task automatic trim_file(input int n);
		repeat (n) void'(file_q.pop_back());
	endtask

	task automatic flip_bit(input int idx);
		file_q[idx] = file_q[idx] ^ (8'h01 << $urandom_range(0, 7));
	endtask

	task automatic put_preamble();
		put_le(RIFF_TAG, 4);
		put_le($urandom, 4);
		put_le(WAVE_TAG, 4);
	endtask

	task automatic put_fmt(input int size, input logic [15:0] ch, input logic [31:0] rate,
			input logic [15:0] bits);
		logic [7:0] b;
		put_le(wavhdr_pkg::ID_FMT, 4);
		put_le(size, 4);
		for (int i = 0; i < size + (size & 1); i++) begin
			b = 8'($urandom);
			if (i == 2 || i == 3)
				b = ch[8*(i-2) +: 8];
			else if (i >= 4 && i <= 7)
				b = rate[8*(i-4) +: 8];
			else if (i == 14 || i == 15)
				b = bits[8*(i-14) +: 8];
			file_q.push_back(b);
		end
	endtask

	task automatic put_data_full(input int size);
		put_le(wavhdr_pkg::ID_DATA, 4);
		put_le(size, 4);
		put_rand(size + (size & 1));
	endtask

	task automatic put_junk(input int size);
		put_le($urandom, 4);
		put_le(size, 4);
		put_rand(size + (size & 1));
	endtask

	task automatic put_simple_wave(input logic [15:0] ch, input logic [31:0] rate,
			input logic [15:0] bits, input int dsize);
		put_preamble();
		put_fmt(16, ch, rate, bits);
		put_data_full(dsize);
	endtask

	function automatic logic [15:0] rand_channels();
		int r = $urandom_range(0, 19);
		if (r < 9)
			return 16'd1;
		if (r < 18)
			return 16'd2;
		return 16'($urandom);
	endfunction

	function automatic logic [31:0] rand_rate();
		int r = $urandom_range(0, 19);
		if (r == 0)
			return '0;
		if (r == 1)
			return $urandom;
		return $urandom_range(1, 200000);
	endfunction

	function automatic logic [15:0] rand_depth();
		int r = $urandom_range(0, 19);
		if (r < 9)
			return 16'd8;
		if (r < 18)
			return 16'd16;
		return 16'($urandom);
	endfunction

	// Mostly well-formed files with random content; some noise and broken ones
	task automatic put_random_wave();
		int n_extra;
		if ($urandom_range(0, 11) == 0) begin
			put_rand($urandom_range(1, 60));
			return;
		end
		put_preamble();
		if ($urandom_range(0, 9) == 0)
			flip_bit($urandom_range(0, 11));
		n_extra = $urandom_range(0, 3);
		for (int i = 0; i < n_extra; i++) begin
			case ($urandom_range(0, 3))
				0: put_junk($urandom_range(0, 9));
				1: put_fmt($urandom_range(0, 24), rand_channels(), rand_rate(), rand_depth());
				2: put_data_full($urandom_range(0, 12));
				default: put_junk(0);
			endcase
		end
		if ($urandom_range(0, 5) != 0)
			put_fmt(($urandom_range(0, 4) == 0) ? $urandom_range(10, 30) : 16,
				rand_channels(), rand_rate(), rand_depth());
		if ($urandom_range(0, 5) != 0) begin
			if ($urandom_range(0, 7) == 0) begin
				// declared size runs past the end of the file
				put_le(wavhdr_pkg::ID_DATA, 4);
				put_le($urandom, 4);
				put_rand($urandom_range(0, 16));
			end else begin
				put_data_full($urandom_range(0, 24));
			end
		end
		if ($urandom_range(0, 7) == 0)
			put_junk($urandom_range(0, 9));
		if ($urandom_range(0, 7) == 0 && file_q.size() > 1)
			trim_file($urandom_range(1, file_q.size() - 1));
	endtask

	// ---------------------------------------------------------------- tests

	// Files too short for a header, byte extremes included
	task automatic test_short_files();
		file_q.push_back(8'h00);
		send_file();
		file_q.push_back(8'hFF);
		send_file();
		put_preamble();
		trim_file(7);
		send_file();
		put_preamble();
		put_fmt(16, 16'd1, 32'd8000, 16'd8);
		put_rand(7);
		send_file();
	endtask

	// Every format code, plus field extremes
	task automatic test_pcm_formats();
		put_simple_wave(16'd1, 32'd8000, 16'd8, 5);
		send_file();
		put_simple_wave(16'd1, 32'd44100, 16'd16, 8);
		send_file();
		put_simple_wave(16'd2, 32'd22050, 16'd8, 4);
		send_file();
		put_simple_wave(16'd2, 32'd48000, 16'd16, 12);
		send_file();
		put_simple_wave(16'hFFFF, 32'hFFFF_FFFF, 16'd16, 1);
		send_file();
	endtask

	// Corrupt RIFF or WAVE tag: parsing continues, status reports the tag
	task automatic test_bad_tags();
		put_simple_wave(16'd2, 32'd44100, 16'd16, 6);
		flip_bit($urandom_range(0, 3));
		send_file();
		put_simple_wave(16'd1, 32'd8000, 16'd8, 3);
		flip_bit($urandom_range(8, 11));
		send_file();
	endtask

	// Missing chunks, zero fields and unsupported depth
	task automatic test_missing_fields();
		put_preamble();
		put_fmt(16, 16'd1, 32'd8000, 16'd8);
		put_junk(20);
		send_file();
		put_preamble();
		put_data_full(40);
		send_file();
		put_simple_wave(16'd1, 32'd8000, 16'd8, 0);
		send_file();
		put_simple_wave(16'd0, 32'd8000, 16'd8, 4);
		send_file();
		put_simple_wave(16'd2, 32'd0, 16'd16, 4);
		send_file();
		put_simple_wave(16'd2, 32'd96000, 16'd24, 6);
		send_file();
		put_simple_wave(16'd1, 32'd11025, 16'd0, 2);
		send_file();
	endtask

	// Padding, empty chunks, overriding chunks, clamping and cut-off chunks
	task automatic test_chunk_walk();
		put_preamble();
		put_fmt(12, 16'd3, 32'd1234, 16'd8);
		put_fmt(16, 16'd1, 32'd8000, 16'd8);
		put_fmt(18, 16'd2, 32'd48000, 16'd16);
		put_junk(5);
		put_junk(0);
		put_data_full(3);
		put_data_full(6);
		send_file();
		// data declared far beyond the file end
		put_preamble();
		put_fmt(16, 16'd2, 32'd32000, 16'd8);
		put_le(wavhdr_pkg::ID_DATA, 4);
		put_le(32'hFFFF_FFFF, 4);
		put_rand(10);
		send_file();
		// data body cut short by the file end
		put_preamble();
		put_fmt(16, 16'd1, 32'd16000, 16'd16);
		put_le(wavhdr_pkg::ID_DATA, 4);
		put_le(20, 4);
		put_rand(5);
		send_file();
		// a second fmt chunk cut off before its 16th body byte changes nothing
		put_simple_wave(16'd1, 32'd8000, 16'd16, 4);
		put_fmt(16, 16'd2, 32'd96000, 16'd8);
		trim_file(6);
		send_file();
		// file ends inside a chunk header
		put_simple_wave(16'd2, 32'd44100, 16'd8, 2);
		put_junk(4);
		trim_file(9);
		send_file();
	endtask

	// Long receiver hold-off while short files keep coming, so the input backs up
	task automatic test_backpressure();
		feed_gaps_on = 1'b0;
		hold_off_req = 1'b1;
		repeat (3) begin
			put_rand($urandom_range(1, 3));
			send_file();
		end
		put_simple_wave(16'd2, 32'd44100, 16'd16, 4);
		send_file();
		repeat (3) begin
			put_rand($urandom_range(1, 3));
			send_file();
		end
		feed_gaps_on = 1'b1;
	endtask

	task automatic test_random_files();
		int n_files = 0;
		while (bytes_sent < ITEMS_TOTAL || n_files < RANDOM_FILES) begin
			// some files run with no idling on either side
			feed_gaps_on = ($urandom_range(0, 3) != 0);
			stall_on     = ($urandom_range(0, 3) != 0);
			put_random_wave();
			send_file();
			n_files++;
		end
		feed_gaps_on = 1'b1;
		stall_on     = 1'b1;
	endtask

	// ---------------------------------------------------------------- sequence

	initial begin
		clear_walker();
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_short_files();
		test_pcm_formats();
		test_bad_tags();
		test_missing_fields();
		test_chunk_walk();
		test_backpressure();
		test_random_files();

		@(negedge clk);
		feed_valid <= 1'b0;
		while (expected_headers.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatch_count == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
